>>> src/fttok_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fttok_pkg;

    // Line and field geometry
    localparam int MAX_LINE   = 4096;
    localparam int COL_W      = $clog2(MAX_LINE);
    localparam int LEN_W      = $clog2(MAX_LINE + 1);
    localparam int CHAR_W     = 16;
    localparam int KIND_W     = 4;
    localparam int TSTART_W   = 12;
    localparam int TLEN_W     = 13;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_PAD_W  = OUT_DATA_W - TSTART_W - TLEN_W - 1;
    localparam int IN_USER_W  = 2;
    localparam int MAX_RES    = 3;
    localparam int RES_CNT_W  = $clog2(MAX_RES + 1);

    // Keyword table: end, object, inherited, inline
    localparam int KW_N     = 4;
    localparam int KW_MAX   = 9;
    localparam int KW_IDX_W = $clog2(KW_MAX);
    localparam int KW_LEN [KW_N] = '{3, 6, 9, 6};
    localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_N] = '{
        72'h000000000000_646E65,
        72'h000000_7463656A626F,
        72'h6465746972656_86E69,
        72'h000000_656E696C6E69
    };

    // Character codes
    localparam logic [CHAR_W-1:0] CH_NUL    = 16'h0000;
    localparam logic [CHAR_W-1:0] CH_LF     = 16'h000A;
    localparam logic [CHAR_W-1:0] CH_CR     = 16'h000D;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 16'h0020;
    localparam logic [CHAR_W-1:0] CH_HASH   = 16'h0023;
    localparam logic [CHAR_W-1:0] CH_DOLLAR = 16'h0024;
    localparam logic [CHAR_W-1:0] CH_QUOTE  = 16'h0027;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 16'h0028;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 16'h0029;
    localparam logic [CHAR_W-1:0] CH_COMMA  = 16'h002C;
    localparam logic [CHAR_W-1:0] CH_DOT    = 16'h002E;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 16'h002F;
    localparam logic [CHAR_W-1:0] CH_0      = 16'h0030;
    localparam logic [CHAR_W-1:0] CH_9      = 16'h0039;
    localparam logic [CHAR_W-1:0] CH_LT     = 16'h003C;
    localparam logic [CHAR_W-1:0] CH_EQ     = 16'h003D;
    localparam logic [CHAR_W-1:0] CH_GT     = 16'h003E;
    localparam logic [CHAR_W-1:0] CH_UP_A   = 16'h0041;
    localparam logic [CHAR_W-1:0] CH_UP_E   = 16'h0045;
    localparam logic [CHAR_W-1:0] CH_UP_Z   = 16'h005A;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 16'h005B;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 16'h005D;
    localparam logic [CHAR_W-1:0] CH_UNDER  = 16'h005F;
    localparam logic [CHAR_W-1:0] CH_LO_A   = 16'h0061;
    localparam logic [CHAR_W-1:0] CH_LO_E   = 16'h0065;
    localparam logic [CHAR_W-1:0] CH_LO_F   = 16'h0066;
    localparam logic [CHAR_W-1:0] CH_LO_I   = 16'h0069;
    localparam logic [CHAR_W-1:0] CH_LO_O   = 16'h006F;
    localparam logic [CHAR_W-1:0] CH_LO_Z   = 16'h007A;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 16'h007B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 16'h007D;

    typedef enum logic [KIND_W-1:0] {
        K_NULL    = 4'd0,
        K_COMMENT = 4'd1,
        K_IDENT   = 4'd2,
        K_KEY     = 4'd3,
        K_NUMBER  = 4'd4,
        K_SPACE   = 4'd5,
        K_STRING  = 4'd6,
        K_SYMBOL  = 4'd7,
        K_UNKNOWN = 4'd8
    } t_kind;

    // Scanner state, one-hot
    typedef enum logic [10:0] {
        M_IDLE   = 11'b000_0000_0001,
        M_IDENT  = 11'b000_0000_0010,
        M_NUM    = 11'b000_0000_0100,
        M_NUMDOT = 11'b000_0000_1000,
        M_HEX    = 11'b000_0001_0000,
        M_CODE   = 11'b000_0010_0000,
        M_STR    = 11'b000_0100_0000,
        M_STRQ   = 11'b000_1000_0000,
        M_COMM   = 11'b001_0000_0000,
        M_SPACE  = 11'b010_0000_0000,
        M_CR     = 11'b100_0000_0000
    } t_mode;

    typedef struct packed {
        logic              in_comment;
        t_mode             mode;
        logic [COL_W-1:0]  open_start;
        logic [LEN_W-1:0]  open_len;
        logic [COL_W-1:0]  column;
        logic [KW_N-1:0]   kw;
    } t_scan_state;

    typedef struct packed {
        t_kind             kind;
        logic [COL_W-1:0]  start;
        logic [LEN_W-1:0]  length;
        logic              comment_open;
        logic              last;
    } t_res;

    function automatic logic [CHAR_W-1:0] f_lower(input logic [CHAR_W-1:0] c);
        return (c >= CH_UP_A && c <= CH_UP_Z) ? c + CHAR_W'(32) : c;
    endfunction

    function automatic logic f_is_digit(input logic [CHAR_W-1:0] c);
        return c >= CH_0 && c <= CH_9;
    endfunction

    function automatic logic f_is_alpha(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] l;
        l = f_lower(c);
        return c == CH_UNDER || (l >= CH_LO_A && l <= CH_LO_Z);
    endfunction

    function automatic logic f_is_ident(input logic [CHAR_W-1:0] c);
        return f_is_alpha(c) || f_is_digit(c);
    endfunction

    function automatic logic f_is_hex(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] l;
        l = f_lower(c);
        return f_is_digit(c) || (l >= CH_LO_A && l <= CH_LO_F);
    endfunction

    function automatic logic f_is_break(input logic [CHAR_W-1:0] c);
        return c == CH_CR || c == CH_LF;
    endfunction

    function automatic logic f_is_symbol(input logic [CHAR_W-1:0] c);
        return c == CH_LPAREN || c == CH_RPAREN || c == CH_SLASH || c == CH_EQ ||
               c == CH_LT || c == CH_GT || c == CH_DOT || c == CH_COMMA ||
               c == CH_LBRACK || c == CH_RBRACK;
    endfunction

    function automatic logic [LEN_W-1:0] f_grow(input logic [LEN_W-1:0] len);
        return (len < LEN_W'(MAX_LINE)) ? len + 1'b1 : len;
    endfunction

    // Keyword candidates opened by the first letter
    function automatic logic [KW_N-1:0] f_kw_start(input logic [CHAR_W-1:0] lc);
        logic [KW_N-1:0] kw;
        kw = '0;
        if (lc == CH_LO_E) kw = 4'b0001;
        if (lc == CH_LO_O) kw = 4'b0010;
        if (lc == CH_LO_I) kw = 4'b1100;
        return kw;
    endfunction

    // Drop candidates that the next letter rules out
    function automatic logic [KW_N-1:0] f_kw_next(input logic [KW_N-1:0] kw,
                                                  input logic [LEN_W-1:0] len,
                                                  input logic [CHAR_W-1:0] lc);
        logic [KW_N-1:0] res;
        logic [7:0]      ch;
        res = kw;
        for (int k = 0; k < KW_N; k++) begin
            ch = (len < LEN_W'(KW_MAX)) ?
                 KW_TEXT[k][8*len[KW_IDX_W-1:0] +: 8] : 8'h00;
            if (!(len < LEN_W'(KW_LEN[k]) && {8'h00, ch} == lc))
                res[k] = 1'b0;
        end
        return res;
    endfunction

    function automatic t_kind f_open_kind(input t_mode mode, input logic [KW_N-1:0] kw,
                                          input logic [LEN_W-1:0] len);
        t_kind kind;
        kind = K_UNKNOWN;
        unique case (mode)
            M_IDENT: begin
                kind = K_IDENT;
                for (int k = 0; k < KW_N; k++)
                    if (kw[k] && len == LEN_W'(KW_LEN[k]))
                        kind = K_KEY;
            end
            M_NUM, M_NUMDOT, M_HEX: kind = K_NUMBER;
            M_CODE, M_STR, M_STRQ:  kind = K_STRING;
            M_COMM:                 kind = K_COMMENT;
            M_SPACE, M_CR:          kind = K_SPACE;
            default:                kind = K_UNKNOWN;
        endcase
        return kind;
    endfunction

    // Result for the token that is open in s
    function automatic t_res f_open_res(input t_scan_state s);
        t_res r;
        r.kind         = f_open_kind(s.mode, s.kw, s.open_len);
        r.start        = s.open_start;
        r.length       = s.open_len;
        r.comment_open = s.in_comment;
        r.last         = 1'b0;
        return r;
    endfunction

    function automatic t_res f_one_res(input t_kind kind, input logic [COL_W-1:0] start,
                                       input logic [LEN_W-1:0] len, input logic inc);
        t_res r;
        r.kind         = kind;
        r.start        = start;
        r.length       = len;
        r.comment_open = inc;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/fttok_step.sv
`timescale 1ns / 1ps
`default_nettype none

module fttok_step
    import fttok_pkg::*;
(
    input  var t_scan_state               i_state,
    input  wire logic [CHAR_W-1:0]        i_char,
    input  wire logic                     i_ls,
    input  wire logic                     i_sic,
    input  wire logic                     i_le,
    output t_scan_state                   o_state,
    output t_res [MAX_RES-1:0]            o_res,
    output logic [RES_CNT_W-1:0]          o_cnt
);

    t_scan_state               v;
    t_res [MAX_RES-1:0]        res;
    logic [RES_CNT_W-1:0]      cnt;
    logic                      absorb;
    logic [CHAR_W-1:0]         lc;

    // Walk one character through line start, scan and line end
    always_comb begin
        v      = i_state;
        res    = '0;
        cnt    = '0;
        absorb = 1'b0;
        lc     = f_lower(i_char);

        // Flush a token left over from the previous line
        if (i_ls) begin
            if (v.mode != M_IDLE) begin
                res[cnt] = f_open_res(v);
                cnt      = cnt + 1'b1;
            end
            v.mode       = M_IDLE;
            v.kw         = '0;
            v.column     = '0;
            v.in_comment = i_sic;
        end

        // Offer the character to the open token
        unique case (v.mode)
            M_IDLE: ;
            M_IDENT: begin
                if (f_is_ident(i_char)) begin
                    v.kw       = f_kw_next(v.kw, v.open_len, lc);
                    v.open_len = f_grow(v.open_len);
                    absorb     = 1'b1;
                end
            end
            M_NUM: begin
                if (i_char == CH_DOT) begin
                    v.open_len = f_grow(v.open_len);
                    v.mode     = M_NUMDOT;
                    absorb     = 1'b1;
                end else if (f_is_digit(i_char) || i_char == CH_LO_E || i_char == CH_UP_E) begin
                    v.open_len = f_grow(v.open_len);
                    absorb     = 1'b1;
                end
            end
            M_NUMDOT: begin
                // second dot: number ends before the first dot, which is a symbol
                if (i_char == CH_DOT) begin
                    res[cnt] = f_one_res(K_NUMBER, v.open_start,
                                         (v.open_len > LEN_W'(1)) ? v.open_len - 1'b1
                                                                  : LEN_W'(1),
                                         v.in_comment);
                    cnt      = cnt + 1'b1;
                    res[cnt] = f_one_res(K_SYMBOL,
                                         (v.column != '0) ? v.column - 1'b1 : '0,
                                         LEN_W'(1), v.in_comment);
                    cnt      = cnt + 1'b1;
                    v.mode   = M_IDLE;
                end
            end
            M_HEX: begin
                if (f_is_hex(i_char)) begin
                    v.open_len = f_grow(v.open_len);
                    absorb     = 1'b1;
                end
            end
            M_CODE: begin
                if (f_is_digit(i_char)) begin
                    v.open_len = f_grow(v.open_len);
                    absorb     = 1'b1;
                end
            end
            M_STR: begin
                if (i_char == CH_QUOTE) begin
                    v.open_len = f_grow(v.open_len);
                    v.mode     = M_STRQ;
                    absorb     = 1'b1;
                end else if (!f_is_break(i_char)) begin
                    v.open_len = f_grow(v.open_len);
                    absorb     = 1'b1;
                end
            end
            M_STRQ: begin
                if (i_char == CH_QUOTE) begin
                    v.open_len = f_grow(v.open_len);
                    v.mode     = M_STR;
                    absorb     = 1'b1;
                end
            end
            M_COMM: begin
                if (i_char == CH_RBRACE) begin
                    v.open_len   = f_grow(v.open_len);
                    v.in_comment = 1'b0;
                    res[cnt]     = f_open_res(v);
                    cnt          = cnt + 1'b1;
                    v.mode       = M_IDLE;
                    v.kw         = '0;
                    absorb       = 1'b1;
                end else if (!f_is_break(i_char)) begin
                    v.open_len = f_grow(v.open_len);
                    absorb     = 1'b1;
                end
            end
            M_SPACE: begin
                if (i_char <= CH_SPACE && !f_is_break(i_char)) begin
                    v.open_len = f_grow(v.open_len);
                    absorb     = 1'b1;
                end
            end
            M_CR: begin
                if (i_char == CH_LF) begin
                    v.open_len = f_grow(v.open_len);
                    res[cnt]   = f_open_res(v);
                    cnt        = cnt + 1'b1;
                    v.mode     = M_IDLE;
                    v.kw       = '0;
                    absorb     = 1'b1;
                end
            end
            default: ;
        endcase

        // Close the open token and start a new one at this character
        if (!absorb) begin
            if (v.mode != M_IDLE) begin
                res[cnt] = f_open_res(v);
                cnt      = cnt + 1'b1;
            end
            v.mode     = M_IDLE;
            v.kw       = '0;
            v.open_start = v.column;
            v.open_len   = LEN_W'(1);
            if (v.in_comment) begin
                if (i_char == CH_NUL) begin
                    res[cnt] = f_one_res(K_NULL, v.column, LEN_W'(1), v.in_comment);
                    cnt      = cnt + 1'b1;
                end else begin
                    v.mode = M_COMM;
                end
            end else begin
                priority if (f_is_alpha(i_char)) begin
                    v.mode = M_IDENT;
                    v.kw   = f_kw_start(lc);
                end else if (f_is_digit(i_char)) begin
                    v.mode = M_NUM;
                end else if (i_char == CH_DOLLAR) begin
                    v.mode = M_HEX;
                end else if (i_char == CH_HASH) begin
                    v.mode = M_CODE;
                end else if (i_char == CH_QUOTE) begin
                    v.mode = M_STR;
                end else if (i_char == CH_LBRACE) begin
                    v.in_comment = 1'b1;
                    v.mode       = M_COMM;
                end else if (i_char == CH_CR) begin
                    v.mode = M_CR;
                end else if (i_char == CH_LF) begin
                    res[cnt] = f_one_res(K_SPACE, v.column, LEN_W'(1), v.in_comment);
                    cnt      = cnt + 1'b1;
                end else if (i_char == CH_NUL) begin
                    res[cnt] = f_one_res(K_NULL, v.column, LEN_W'(1), v.in_comment);
                    cnt      = cnt + 1'b1;
                end else if (i_char <= CH_SPACE) begin
                    v.mode = M_SPACE;
                end else if (i_char == CH_RBRACE) begin
                    res[cnt] = f_one_res(K_IDENT, v.column, LEN_W'(1), v.in_comment);
                    cnt      = cnt + 1'b1;
                end else if (f_is_symbol(i_char)) begin
                    res[cnt] = f_one_res(K_SYMBOL, v.column, LEN_W'(1), v.in_comment);
                    cnt      = cnt + 1'b1;
                end else begin
                    res[cnt] = f_one_res(K_UNKNOWN, v.column, LEN_W'(1), v.in_comment);
                    cnt      = cnt + 1'b1;
                end
            end
        end

        // Advance the column, saturating at the line limit
        if (v.column < COL_W'(MAX_LINE - 1))
            v.column = v.column + 1'b1;

        // Flush at line end
        if (i_le) begin
            if (v.mode != M_IDLE) begin
                res[cnt] = f_open_res(v);
                cnt      = cnt + 1'b1;
            end
            v.mode   = M_IDLE;
            v.kw     = '0;
            v.column = '0;
        end

        // Mark the final result of this character
        if (cnt != '0)
            res[cnt - 1'b1].last = 1'b1;

        o_state = v;
        o_res   = res;
        o_cnt   = cnt;
    end

endmodule

`default_nettype wire

>>> src/fttok_rbuf.sv
`timescale 1ns / 1ps
`default_nettype none

module fttok_rbuf
    import fttok_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_load,
    input  var t_res [MAX_RES-1:0]       i_res,
    input  wire logic [RES_CNT_W-1:0]    i_cnt,
    input  wire logic                    i_ready,
    output logic                         o_valid,
    output t_res                         o_head,
    output logic                         o_can_load
);

    t_res [MAX_RES-1:0]      r_ent;
    t_res [MAX_RES-1:0]      n_ent;
    logic [RES_CNT_W-1:0]    r_cnt;
    logic [RES_CNT_W-1:0]    n_cnt;
    logic                    w_pop;

    // Take a new group once the last waiting beat leaves
    assign w_pop      = (r_cnt != '0) && i_ready;
    assign o_can_load = (r_cnt == '0) || (r_cnt == RES_CNT_W'(1) && w_pop);
    assign o_valid    = (r_cnt != '0);
    assign o_head     = r_ent[0];

    // Load a group or shift the queue down by one beat
    always_comb begin
        n_ent = r_ent;
        n_cnt = r_cnt;
        if (i_load && o_can_load) begin
            n_ent = i_res;
            n_cnt = i_cnt;
        end else if (w_pop) begin
            for (int i = 0; i < MAX_RES - 1; i++)
                n_ent[i] = r_ent[i+1];
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent <= n_ent;
    end

    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == RES_CNT_W'(1) |-> r_ent[0].last)
        else $error("lone waiting result lacks last mark");

    a_not_last_has_follower: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) && !r_ent[0].last |-> r_cnt > RES_CNT_W'(1))
        else $error("result without last mark has no follower");

    a_load_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_can_load)
        else $error("group loaded while results still wait");

endmodule

`default_nettype wire

>>> src/form_text_tokenizer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Beat content
// s_*      in   tdata: char_code[15:0]; tuser: line_start, start_in_comment; tlast: line_end
// m_*      out  tdata: token_start, token_length, comment_open; tuser: token_kind;
//               tlast: last_result
//
// One character per cycle while the output queue has room: a beat waits in the input
// register, the scan step runs on it and its results load the output queue in the same edge.
// A character that closes N tokens (N at most 3) puts N beats in the three-entry output
// queue; the next one loads as the last leaves. Characters that close nothing add no beat.
// Synchronous active-low reset clears the scanner state, the input register and the queue.
// A stalled output keeps one further character in the input register before s_tready drops.

module form_text_tokenizer_core
    import fttok_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [CHAR_W-1:0]      i_s_tdata,   // char_code
    input  wire logic [IN_USER_W-1:0]   i_s_tuser,   // line_start, start_in_comment
    input  wire logic                   i_s_tlast,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_DATA_W-1:0]       o_m_tdata,   // token_start, token_length, comment_open
    output logic [KIND_W-1:0]           o_m_tuser,   // token_kind
    output logic                        o_m_tlast
);

    logic                      r_in_vld;
    logic [CHAR_W-1:0]         r_char;
    logic                      r_ls;
    logic                      r_sic;
    logic                      r_le;
    t_scan_state               r_state;
    t_scan_state               n_state;
    t_res [MAX_RES-1:0]        w_res;
    logic [RES_CNT_W-1:0]      w_cnt;
    logic                      w_can_load;
    logic                      w_consume;
    t_res                      w_head;

    assign w_consume  = r_in_vld && w_can_load;
    assign o_s_tready = !r_in_vld || w_consume;

    // Hold one input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_vld <= 1'b1;
        end else if (w_consume) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_char <= i_s_tdata;
            r_ls   <= i_s_tuser[0];
            r_sic  <= i_s_tuser[1];
            r_le   <= i_s_tlast;
        end
    end

    // Scan step
    fttok_step u_step (
        .i_state (r_state),
        .i_char  (r_char),
        .i_ls    (r_ls),
        .i_sic   (r_sic),
        .i_le    (r_le),
        .o_state (n_state),
        .o_res   (w_res),
        .o_cnt   (w_cnt)
    );

    // Advance the scanner when the character's results are queued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.in_comment <= 1'b0;
            r_state.mode       <= M_IDLE;
            r_state.open_start <= '0;
            r_state.open_len   <= '0;
            r_state.column     <= '0;
            r_state.kw         <= '0;
        end else if (w_consume) begin
            r_state <= n_state;
        end
    end

    fttok_rbuf u_rbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_consume),
        .i_res      (w_res),
        .i_cnt      (w_cnt),
        .i_ready    (i_m_tready),
        .o_valid    (o_m_tvalid),
        .o_head     (w_head),
        .o_can_load (w_can_load)
    );

    // Pack the output beat
    assign o_m_tdata = {OUT_PAD_W'(0), w_head.comment_open,
                        TLEN_W'(w_head.length), TSTART_W'(w_head.start)};
    assign o_m_tuser = w_head.kind;
    assign o_m_tlast = w_head.last;

    a_open_has_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.mode != M_IDLE |-> r_state.open_len != '0)
        else $error("open token with zero length");

    a_comment_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.mode == M_COMM |-> r_state.in_comment)
        else $error("comment token open without comment flag");

    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_consume |=> $stable(r_state))
        else $error("scanner state moved without a character");

    a_input_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !w_consume |=> r_in_vld && $stable(r_char))
        else $error("waiting character lost");

endmodule

`default_nettype wire
